// File: src/car1_pkg.sv
// Shared types, constants and the exp(-1) series constant for the CAR(1) Kalman predictor.
`timescale 1ns / 1ps
package car1_pkg;

  localparam int DATA_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int WIDE_W       = 64;
  localparam int PROD_W       = 2 * WIDE_W;
  localparam int Q62_FRAC     = 62;
  localparam int Q62_SHIFT    = Q62_FRAC - FRAC_W;
  localparam int RHO_W        = FRAC_W + 1;
  localparam int TAYLOR_TERMS = 24;
  localparam int TERM_W       = 5;
  localparam int EXP_LIMIT_W  = 6;

  localparam logic [DATA_W-1:0] DATA_MAX = '1;
  localparam logic [RHO_W-1:0]  FX_ONE   = RHO_W'(1) << FRAC_W;
  localparam logic [WIDE_W-1:0] Q62_ONE  = WIDE_W'(1) << Q62_FRAC;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_value;
    logic        [DATA_W-1:0] sample_error;
    logic        [DATA_W-1:0] gap_to_next;
    logic                     series_start;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pred_mean;
    logic        [DATA_W-1:0] pred_var;
    logic                     saturated;
  } result_t;

  typedef enum logic {
    ITEM_UPDATE,
    ITEM_START
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    sample_t    word;
  } cmd_t;

  typedef enum logic {
    REG_DECAY_RATE     = 1'b0,
    REG_DRIVE_VARIANCE = 1'b1
  } reg_index_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_STAT,
    S_STAT_D,
    S_E2,
    S_E2_D,
    S_START_VAR,
    S_X,
    S_X_D,
    S_T_D,
    S_K_D,
    S_E_D,
    S_ROUND,
    S_LE2,
    S_LE2_D,
    S_RATIO_D,
    S_G,
    S_G_D,
    S_P_D,
    S_R2_D,
    S_A_D,
    S_B1_D,
    S_B2_D,
    S_WAIT,
    S_OUT
  } state_t;

  // exp(-1) in Q2.62 from the same truncated alternating series the datapath runs
  function automatic logic [WIDE_W-1:0] exp_neg_one_q62();
    logic [PROD_W-1:0] p;
    logic [WIDE_W-1:0] s;
    logic [WIDE_W-1:0] t;
    s = Q62_ONE;
    t = Q62_ONE;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      p = PROD_W'(t) * PROD_W'(Q62_ONE);
      t = p[Q62_FRAC +: WIDE_W];
      t = t / WIDE_W'(k);
      if ((k % 2) == 1) begin
        s = (t > s) ? '0 : s - t;
      end else begin
        s = s + t;
      end
    end
    return s;
  endfunction

  localparam logic [WIDE_W-1:0] E1_Q62 = exp_neg_one_q62();

endpackage

// File: src/car1_kalman_filter_top.sv
// Top level of the CAR(1) Kalman predictor: configuration registers, front and back ends.
`timescale 1ns / 1ps
// One-step Kalman predictor for an irregularly sampled CAR(1) series in Q16.16. Write
// decay_rate (index 0) and drive_variance (index 1) while the block is idle; both reset
// to 1.0. Each sample word gives one result word, in order. A start sample, or the first
// sample after reset, skips the prediction steps. Any other sample runs the exp(-x) series
// and multiplies by exp(-1) once for each whole unit of decay_rate times the previous gap
// (up to 63); it skips the series when that product reaches 64 and skips the ratio
// division when the previous variance is zero. The shared divider yields one quotient bit
// per cycle and runs once per series term of exp(-x), and all products go through the
// shared 64x64 multiplier.
// Two sample words queue at the input and one result word waits at the output, so both
// sides stall independently.
module car1_kalman_filter_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  car1_pkg::sample_t            sample,
  output logic                         full,
  output logic                         empty,
  input  logic                         pop,
  output car1_pkg::result_t            result,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [car1_pkg::DATA_W-1:0]  cfg_data
);

  logic [car1_pkg::DATA_W-1:0] decay_rate;
  logic [car1_pkg::DATA_W-1:0] drive_variance;
  logic                        cmd_valid;
  car1_pkg::cmd_t              cmd;
  logic                        cmd_take;
  logic                        out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_rate     <= car1_pkg::DATA_W'(car1_pkg::FX_ONE);
      drive_variance <= car1_pkg::DATA_W'(car1_pkg::FX_ONE);
    end else if (cfg_we) begin
      case (car1_pkg::reg_index_t'(cfg_addr))
        car1_pkg::REG_DECAY_RATE:     decay_rate     <= cfg_data;
        car1_pkg::REG_DRIVE_VARIANCE: drive_variance <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  car1_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .sample    (sample),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  car1_back u_back (
    .clk            (clk),
    .rst            (rst),
    .decay_rate     (decay_rate),
    .drive_variance (drive_variance),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_take       (cmd_take),
    .pop            (pop),
    .out_valid      (out_valid),
    .result         (result)
  );

  assign empty = !out_valid;

endmodule

// File: src/car1_mul.sv
// Shared 64x64 multiplier: four 32x32 partial products accumulated in turn.
`timescale 1ns / 1ps
module car1_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [car1_pkg::WIDE_W-1:0]   a,
  input  logic [car1_pkg::WIDE_W-1:0]   b,
  output logic                          done,
  output logic [car1_pkg::PROD_W-1:0]   prod
);

  localparam int HALF_W = car1_pkg::WIDE_W / 2;

  logic [car1_pkg::WIDE_W-1:0] opa;
  logic [car1_pkg::WIDE_W-1:0] opb;
  logic [2:0]                  cnt;
  logic                        busy;
  logic [car1_pkg::WIDE_W-1:0] pp;
  logic [1:0]                  pp_sel;
  logic [car1_pkg::PROD_W-1:0] acc;
  logic [HALF_W-1:0]           a_half;
  logic [HALF_W-1:0]           b_half;
  logic [car1_pkg::PROD_W-1:0] pp_shifted;

  assign a_half = cnt[1] ? opa[car1_pkg::WIDE_W-1:HALF_W] : opa[HALF_W-1:0];
  assign b_half = cnt[0] ? opb[car1_pkg::WIDE_W-1:HALF_W] : opb[HALF_W-1:0];

  always_comb begin
    case (pp_sel)
      2'd0:    pp_shifted = car1_pkg::PROD_W'(pp);
      2'd3:    pp_shifted = car1_pkg::PROD_W'(pp) << car1_pkg::WIDE_W;
      default: pp_shifted = car1_pkg::PROD_W'(pp) << HALF_W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        opa  <= a;
        opb  <= b;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt < 3'd4) begin
          pp     <= car1_pkg::WIDE_W'(a_half) * car1_pkg::WIDE_W'(b_half);
          pp_sel <= cnt[1:0];
        end
        if (cnt != 3'd0) begin
          acc <= acc + pp_shifted;
        end
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

// File: src/car1_div.sv
// Shared restoring divider: 64-bit dividend, 32-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module car1_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [car1_pkg::WIDE_W-1:0]   num,
  input  logic [car1_pkg::DATA_W-1:0]   den,
  output logic                          done,
  output logic [car1_pkg::WIDE_W-1:0]   quo
);

  localparam int CNT_W = $clog2(car1_pkg::WIDE_W);

  logic [car1_pkg::WIDE_W-1:0] nsh;
  logic [car1_pkg::DATA_W-1:0] d;
  logic [car1_pkg::DATA_W-1:0] rem;
  logic [CNT_W-1:0]            cnt;
  logic                        busy;
  logic [car1_pkg::DATA_W:0]   trial;
  logic                        ge;

  assign trial = {rem, nsh[car1_pkg::WIDE_W-1]};
  assign ge    = trial >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        nsh  <= num;
        d    <= den;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        rem <= ge ? car1_pkg::DATA_W'(trial - {1'b0, d}) : trial[car1_pkg::DATA_W-1:0];
        quo <= {quo[car1_pkg::WIDE_W-2:0], ge};
        nsh <= nsh << 1;
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/car1_front.sv
// Input side: two-entry queue that takes sample words and tags start-of-series items.
`timescale 1ns / 1ps
module car1_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  car1_pkg::sample_t sample,
  output logic              full,
  output logic              cmd_valid,
  output car1_pkg::cmd_t    cmd,
  input  logic              cmd_take
);

  car1_pkg::cmd_t slots [2];
  logic [1:0]     count;
  logic           wr_ptr;
  logic           rd_ptr;
  logic           accept;
  logic           take;
  car1_pkg::cmd_t incoming;

  assign full      = count == 2'd2;
  assign cmd_valid = count != 2'd0;
  assign accept    = push && !full;
  assign take      = cmd_take && cmd_valid;
  assign cmd       = slots[rd_ptr];

  assign incoming.kind = sample.series_start ? car1_pkg::ITEM_START : car1_pkg::ITEM_UPDATE;
  assign incoming.word = sample;

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      case ({accept, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/car1_back.sv
// Back end: sequencer over the shared multiplier and divider, filter state and result register.
`timescale 1ns / 1ps
module car1_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [car1_pkg::DATA_W-1:0]  decay_rate,
  input  logic [car1_pkg::DATA_W-1:0]  drive_variance,
  input  logic                         cmd_valid,
  input  car1_pkg::cmd_t               cmd,
  output logic                         cmd_take,
  input  logic                         pop,
  output logic                         out_valid,
  output car1_pkg::result_t            result
);

  localparam int DW = car1_pkg::DATA_W;
  localparam int FW = car1_pkg::FRAC_W;
  localparam int WW = car1_pkg::WIDE_W;
  localparam int RW = car1_pkg::RHO_W;

  car1_pkg::state_t state, state_next;
  car1_pkg::state_t ret, ret_next;

  logic                              have_prev;
  logic [DW-1:0]                     last_mean;
  logic [DW-1:0]                     last_var;
  logic [DW-1:0]                     last_value;
  logic [DW-1:0]                     last_error;
  logic [DW-1:0]                     last_gap;

  logic [DW-1:0]                     cur_value;
  logic [DW-1:0]                     cur_error;
  logic [DW-1:0]                     cur_gap;
  logic                              start_eff;
  logic [DW-1:0]                     stat;
  logic                              stat_sat;
  logic [DW-1:0]                     e2;
  logic                              sat;
  logic [car1_pkg::EXP_LIMIT_W-1:0]  n;
  logic [car1_pkg::EXP_LIMIT_W-1:0]  cnt;
  logic [FW-1:0]                     fq;
  logic [car1_pkg::TERM_W-1:0]       k;
  logic [WW-1:0]                     s;
  logic [RW-1:0]                     rho;
  logic [DW-1:0]                     pv;
  logic [RW-1:0]                     ratio;
  logic [DW-1:0]                     tval;
  logic [DW-1:0]                     mean;
  logic [RW-1:0]                     r2;
  logic [DW-1:0]                     a_term;
  logic [DW-1:0]                     var_q;

  logic                              mul_start;
  logic [WW-1:0]                     mul_a;
  logic [WW-1:0]                     mul_b;
  logic                              mul_done;
  logic [car1_pkg::PROD_W-1:0]       mul_prod;
  logic                              div_start;
  logic [WW-1:0]                     div_num;
  logic [DW-1:0]                     div_den;
  logic                              div_done;
  logic [WW-1:0]                     quo;

  logic [DW-1:0]                     p_fx;
  logic                              p_over;
  logic [WW-1:0]                     p_q62;
  logic                              q_over;
  logic [DW-1:0]                     q_lo;
  logic [DW-1:0]                     x_sat;
  logic                              n_big;
  logic [WW-1:0]                     s_upd;
  logic [WW-1:0]                     rnd;
  logic [WW-car1_pkg::Q62_SHIFT-1:0] rho_raw;
  logic [DW-1:0]                     le2_c;
  logic [DW-1:0]                     pv_c;
  logic                              up;
  logic [DW-1:0]                     diff;
  logic [DW-1:0]                     t_c;
  logic [DW-1:0]                     tmag;
  logic [RW-1:0]                     r2_c;
  logic [DW:0]                       sum1;
  logic [DW-1:0]                     s1;
  logic [DW:0]                       sum2;
  logic [DW:0]                       sum_start;
  logic                              out_free;

  car1_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  car1_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  assign p_fx    = mul_prod[FW +: DW];
  assign p_over  = |mul_prod[2*DW-1:DW+FW];
  assign p_q62   = mul_prod[car1_pkg::Q62_FRAC +: WW];
  assign q_over  = |quo[WW-1:DW];
  assign q_lo    = quo[DW-1:0];
  assign x_sat   = p_over ? car1_pkg::DATA_MAX : p_fx;
  assign n_big   = |x_sat[DW-1:FW+car1_pkg::EXP_LIMIT_W];
  assign s_upd   = k[0] ? ((quo > s) ? '0 : s - quo) : s + quo;
  assign rnd     = s + (WW'(1) << (car1_pkg::Q62_SHIFT - 1));
  assign rho_raw = rnd[WW-1:car1_pkg::Q62_SHIFT];
  assign le2_c   = p_over ? car1_pkg::DATA_MAX : p_fx;
  assign pv_c    = (last_var > le2_c) ? last_var - le2_c : '0;
  assign up      = $signed(last_value) >= $signed(last_mean);
  assign diff    = up ? last_value - last_mean : last_mean - last_value;
  assign t_c     = up ? last_mean + p_fx : last_mean - p_fx;
  assign tmag    = t_c[DW-1] ? (~t_c + 1'b1) : t_c;
  assign r2_c    = (p_fx > DW'(car1_pkg::FX_ONE)) ? car1_pkg::FX_ONE : p_fx[RW-1:0];
  assign sum1    = {1'b0, a_term} + {1'b0, p_fx};
  assign s1      = sum1[DW] ? car1_pkg::DATA_MAX : sum1[DW-1:0];
  assign sum2    = {1'b0, s1} + {1'b0, e2};
  assign sum_start = {1'b0, stat} + {1'b0, e2};
  assign out_free  = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= car1_pkg::S_IDLE;
      ret   <= car1_pkg::S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd_take   = 1'b0;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    case (state)
      car1_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_take   = 1'b1;
          state_next = car1_pkg::S_STAT;
        end
      end
      car1_pkg::S_STAT: begin
        if (decay_rate == '0) begin
          state_next = car1_pkg::S_E2;
        end else begin
          div_start  = 1'b1;
          div_num    = WW'({drive_variance, FW'(0)});
          div_den    = decay_rate;
          state_next = car1_pkg::S_WAIT;
          ret_next   = car1_pkg::S_STAT_D;
        end
      end
      car1_pkg::S_STAT_D: state_next = car1_pkg::S_E2;
      car1_pkg::S_E2: begin
        mul_start  = 1'b1;
        mul_a      = WW'(cur_error);
        mul_b      = WW'(cur_error);
        state_next = car1_pkg::S_WAIT;
        ret_next   = car1_pkg::S_E2_D;
      end
      car1_pkg::S_E2_D: state_next = start_eff ? car1_pkg::S_START_VAR : car1_pkg::S_X;
      car1_pkg::S_START_VAR: state_next = car1_pkg::S_OUT;
      car1_pkg::S_X: begin
        mul_start  = 1'b1;
        mul_a      = WW'(decay_rate);
        mul_b      = WW'(last_gap);
        state_next = car1_pkg::S_WAIT;
        ret_next   = car1_pkg::S_X_D;
      end
      car1_pkg::S_X_D: begin
        if (n_big) begin
          state_next = car1_pkg::S_LE2;
        end else begin
          mul_start  = 1'b1;
          mul_a      = car1_pkg::Q62_ONE;
          mul_b      = WW'(x_sat[FW-1:0]) << car1_pkg::Q62_SHIFT;
          state_next = car1_pkg::S_WAIT;
          ret_next   = car1_pkg::S_T_D;
        end
      end
      car1_pkg::S_T_D: begin
        div_start  = 1'b1;
        div_num    = p_q62;
        div_den    = DW'(k);
        state_next = car1_pkg::S_WAIT;
        ret_next   = car1_pkg::S_K_D;
      end
      car1_pkg::S_K_D: begin
        if (k == car1_pkg::TERM_W'(car1_pkg::TAYLOR_TERMS)) begin
          if (n == '0) begin
            state_next = car1_pkg::S_ROUND;
          end else begin
            mul_start  = 1'b1;
            mul_a      = s_upd;
            mul_b      = car1_pkg::E1_Q62;
            state_next = car1_pkg::S_WAIT;
            ret_next   = car1_pkg::S_E_D;
          end
        end else begin
          mul_start  = 1'b1;
          mul_a      = quo;
          mul_b      = WW'(fq) << car1_pkg::Q62_SHIFT;
          state_next = car1_pkg::S_WAIT;
          ret_next   = car1_pkg::S_T_D;
        end
      end
      car1_pkg::S_E_D: begin
        if (cnt == car1_pkg::EXP_LIMIT_W'(1)) begin
          state_next = car1_pkg::S_ROUND;
        end else begin
          mul_start  = 1'b1;
          mul_a      = p_q62;
          mul_b      = car1_pkg::E1_Q62;
          state_next = car1_pkg::S_WAIT;
          ret_next   = car1_pkg::S_E_D;
        end
      end
      car1_pkg::S_ROUND: state_next = car1_pkg::S_LE2;
      car1_pkg::S_LE2: begin
        mul_start  = 1'b1;
        mul_a      = WW'(last_error);
        mul_b      = WW'(last_error);
        state_next = car1_pkg::S_WAIT;
        ret_next   = car1_pkg::S_LE2_D;
      end
      car1_pkg::S_LE2_D: begin
        if (last_var == '0) begin
          state_next = car1_pkg::S_G;
        end else begin
          div_start  = 1'b1;
          div_num    = WW'({pv_c, FW'(0)});
          div_den    = last_var;
          state_next = car1_pkg::S_WAIT;
          ret_next   = car1_pkg::S_RATIO_D;
        end
      end
      car1_pkg::S_RATIO_D: state_next = car1_pkg::S_G;
      car1_pkg::S_G: begin
        mul_start  = 1'b1;
        mul_a      = WW'(ratio);
        mul_b      = WW'(diff);
        state_next = car1_pkg::S_WAIT;
        ret_next   = car1_pkg::S_G_D;
      end
      car1_pkg::S_G_D: begin
        mul_start  = 1'b1;
        mul_a      = WW'(tmag);
        mul_b      = WW'(rho);
        state_next = car1_pkg::S_WAIT;
        ret_next   = car1_pkg::S_P_D;
      end
      car1_pkg::S_P_D: begin
        mul_start  = 1'b1;
        mul_a      = WW'(rho);
        mul_b      = WW'(rho);
        state_next = car1_pkg::S_WAIT;
        ret_next   = car1_pkg::S_R2_D;
      end
      car1_pkg::S_R2_D: begin
        mul_start  = 1'b1;
        mul_a      = WW'(stat);
        mul_b      = WW'(car1_pkg::FX_ONE - r2_c);
        state_next = car1_pkg::S_WAIT;
        ret_next   = car1_pkg::S_A_D;
      end
      car1_pkg::S_A_D: begin
        mul_start  = 1'b1;
        mul_a      = WW'(r2);
        mul_b      = WW'(pv);
        state_next = car1_pkg::S_WAIT;
        ret_next   = car1_pkg::S_B1_D;
      end
      car1_pkg::S_B1_D: begin
        mul_start  = 1'b1;
        mul_a      = WW'(p_fx);
        mul_b      = WW'(car1_pkg::FX_ONE - ratio);
        state_next = car1_pkg::S_WAIT;
        ret_next   = car1_pkg::S_B2_D;
      end
      car1_pkg::S_B2_D: state_next = car1_pkg::S_OUT;
      car1_pkg::S_WAIT: begin
        if (mul_done || div_done) begin
          state_next = ret;
        end
      end
      car1_pkg::S_OUT: begin
        if (out_free) begin
          state_next = car1_pkg::S_IDLE;
        end
      end
      default: state_next = car1_pkg::S_IDLE;
    endcase
  end

  // datapath registers, loaded as the sequencer passes each step
  always_ff @(posedge clk) begin
    case (state)
      car1_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cur_value <= cmd.word.sample_value;
          cur_error <= cmd.word.sample_error;
          cur_gap   <= cmd.word.gap_to_next;
          start_eff <= (cmd.kind == car1_pkg::ITEM_START) || !have_prev;
          sat       <= 1'b0;
          stat_sat  <= 1'b0;
        end
      end
      car1_pkg::S_STAT: begin
        if (decay_rate == '0) begin
          stat     <= car1_pkg::DATA_MAX;
          stat_sat <= 1'b1;
        end
      end
      car1_pkg::S_STAT_D: begin
        stat_sat <= q_over;
        stat     <= (q_over ? car1_pkg::DATA_MAX : q_lo) >> 1;
      end
      car1_pkg::S_E2_D: begin
        e2  <= p_over ? car1_pkg::DATA_MAX : p_fx;
        sat <= sat || p_over;
      end
      car1_pkg::S_START_VAR: begin
        mean  <= '0;
        var_q <= sum_start[DW] ? car1_pkg::DATA_MAX : sum_start[DW-1:0];
        sat   <= sat || sum_start[DW] || stat_sat;
      end
      car1_pkg::S_X_D: begin
        n   <= x_sat[FW +: car1_pkg::EXP_LIMIT_W];
        fq  <= x_sat[FW-1:0];
        s   <= car1_pkg::Q62_ONE;
        k   <= car1_pkg::TERM_W'(1);
        rho <= '0;
      end
      car1_pkg::S_K_D: begin
        s   <= s_upd;
        k   <= k + 1'b1;
        cnt <= n;
      end
      car1_pkg::S_E_D: begin
        s   <= p_q62;
        cnt <= cnt - 1'b1;
      end
      car1_pkg::S_ROUND: begin
        rho <= (rho_raw > (WW - car1_pkg::Q62_SHIFT)'(car1_pkg::FX_ONE)) ?
               car1_pkg::FX_ONE : rho_raw[RW-1:0];
      end
      car1_pkg::S_LE2_D: begin
        pv    <= pv_c;
        ratio <= '0;
      end
      car1_pkg::S_RATIO_D: begin
        ratio <= (q_over || (q_lo > DW'(car1_pkg::FX_ONE))) ? car1_pkg::FX_ONE : q_lo[RW-1:0];
      end
      car1_pkg::S_G_D: tval <= t_c;
      car1_pkg::S_P_D: mean <= tval[DW-1] ? (~p_fx + 1'b1) : p_fx;
      car1_pkg::S_R2_D: r2 <= r2_c;
      car1_pkg::S_A_D: begin
        a_term <= p_fx;
        sat    <= sat || (stat_sat && (r2 != car1_pkg::FX_ONE));
      end
      car1_pkg::S_B2_D: begin
        var_q <= sum2[DW] ? car1_pkg::DATA_MAX : sum2[DW-1:0];
        sat   <= sat || sum1[DW] || sum2[DW];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == car1_pkg::S_OUT && out_free) begin
      result.pred_mean <= mean;
      result.pred_var  <= var_q;
      result.saturated <= sat;
      last_mean        <= mean;
      last_var         <= var_q;
      last_value       <= cur_value;
      last_error       <= cur_error;
      last_gap         <= cur_gap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      have_prev  <= 1'b0;
    end else begin
      if (state == car1_pkg::S_OUT && out_free) begin
        out_valid <= 1'b1;
        have_prev <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  a_rho_range: assert property (@(posedge clk) disable iff (rst)
    state == car1_pkg::S_ROUND |=> rho <= car1_pkg::FX_ONE)
    else $error("rho above one");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(result))
    else $error("waiting result changed");

  a_wait_busy: assert property (@(posedge clk) disable iff (rst)
    state != car1_pkg::S_WAIT && state_next == car1_pkg::S_WAIT |-> mul_start || div_start)
    else $error("wait entered with no unit started");
`endif

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the CAR(1) Kalman predictor top level.
`timescale 1ns / 1ps
module testbench;
  import car1_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic                clk;
  logic                rst;
  logic                push;
  sample_t             sample;
  logic                full;
  logic                empty;
  logic                pop;
  result_t             result;
  logic                cfg_we;
  logic                cfg_addr;
  logic [DATA_W-1:0]   cfg_data;

  car1_kalman_filter_top DUT (
    .clk(clk), .rst(rst), .push(push), .sample(sample), .full(full),
    .empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // predictor state
  logic [63:0] decay_rate_q, drive_var_q;
  logic [63:0] prev_mean, prev_var, prev_value, prev_error, prev_gap;
  logic        prev_valid;

  result_t     expected_results[$];
  int          errors;
  int          send_idle_pct;
  int          pop_stall_pct;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b, inout logic sat);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b}) >> FRAC_W;
    if (prod > 128'hFFFF_FFFF) begin
      sat = 1'b1;
      return 64'hFFFF_FFFF;
    end
    return prod[63:0];
  endfunction

  function automatic logic [63:0] fx_div(logic [63:0] a, logic [63:0] b, inout logic sat);
    logic [127:0] q;
    q = ({64'd0, a} << FRAC_W) / {64'd0, b};
    if (q > 128'hFFFF_FFFF) begin
      sat = 1'b1;
      return 64'hFFFF_FFFF;
    end
    return q[63:0];
  endfunction

  function automatic logic [63:0] fx_add(logic [63:0] a, logic [63:0] b, inout logic sat);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > 65'hFFFF_FFFF) begin
      sat = 1'b1;
      return 64'hFFFF_FFFF;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  function automatic logic [63:0] exp_series(logic [63:0] f);
    logic [63:0] s, t;
    s = Q62_ONE;
    t = Q62_ONE;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      t = q62_mul(t, f) / 64'(k);
      if (k % 2 == 1) s = (t > s) ? 64'd0 : s - t;
      else s = s + t;
    end
    return s;
  endfunction

  function automatic logic [63:0] decay_factor(logic [63:0] x);
    logic [63:0] n, r, e1;
    n = x >> FRAC_W;
    if (n >= 64) return 64'd0;
    r = exp_series((x & 64'hFFFF) << Q62_SHIFT);
    e1 = exp_series(Q62_ONE);
    for (int i = 0; i < n; i++) r = q62_mul(r, e1);
    r = (r + (64'd1 << (61 - FRAC_W))) >> Q62_SHIFT;
    return (r > 64'h10000) ? 64'h10000 : r;
  endfunction

  function automatic logic [63:0] sext32(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic result_t predict_sample(sample_t s);
    logic [63:0] stat, e2, mean, pvar, rho, le2, pv, ratio, m, yp, d, g, t, p, r2, a, b;
    logic        sat, stat_sat, junk, up;
    result_t     r;
    sat = 1'b0;
    stat_sat = 1'b0;
    junk = 1'b0;
    if (decay_rate_q == 0) begin
      stat = 64'hFFFF_FFFF;
      stat_sat = 1'b1;
    end else begin
      stat = fx_div(drive_var_q, decay_rate_q, stat_sat) >> 1;
    end
    e2 = fx_mul(64'(s.sample_error), 64'(s.sample_error), sat);
    if (s.series_start || !prev_valid) begin
      mean = 64'd0;
      pvar = fx_add(stat, e2, sat);
      if (stat_sat) sat = 1'b1;
    end else begin
      rho = decay_factor(fx_mul(decay_rate_q, prev_gap, junk));
      le2 = fx_mul(prev_error, prev_error, junk);
      pv = (prev_var > le2) ? prev_var - le2 : 64'd0;
      ratio = (prev_var == 0) ? 64'd0 : fx_div(pv, prev_var, junk);
      if (ratio > 64'h10000) ratio = 64'h10000;
      m = sext32(prev_mean);
      yp = sext32(prev_value);
      up = $signed(yp) >= $signed(m);
      d = up ? yp - m : m - yp;
      g = fx_mul(ratio, d, junk);
      t = up ? m + g : m - g;
      p = fx_mul(t[63] ? 64'd0 - t : t, rho, junk);
      mean = t[63] ? 64'd0 - p : p;
      r2 = fx_mul(rho, rho, junk);
      if (r2 > 64'h10000) r2 = 64'h10000;
      a = fx_mul(stat, 64'h10000 - r2, sat);
      if (stat_sat && r2 != 64'h10000) sat = 1'b1;
      b = fx_mul(fx_mul(r2, pv, junk), 64'h10000 - ratio, junk);
      pvar = fx_add(fx_add(a, b, sat), e2, sat);
    end
    prev_mean = mean & 64'hFFFF_FFFF;
    prev_var = pvar & 64'hFFFF_FFFF;
    prev_value = 64'(unsigned'(s.sample_value));
    prev_error = 64'(s.sample_error);
    prev_gap = 64'(s.gap_to_next);
    prev_valid = 1'b1;
    r.pred_mean = mean[31:0];
    r.pred_var = pvar[31:0];
    r.saturated = sat;
    return r;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, result);
          errors++;
        end else begin
          if (result !== expected_results[0]) begin
            $display("%0t: mismatch expected mean %h var %h sat %b, actual mean %h var %h sat %b",
                     $time, expected_results[0].pred_mean, expected_results[0].pred_var,
                     expected_results[0].saturated, result.pred_mean, result.pred_var,
                     result.saturated);
            errors++;
          end
          void'(expected_results.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL car1_kalman_filter_top");
        $finish;
      end
    end
  end

  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_results.push_back(predict_sample(s));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DECAY_RATE) decay_rate_q = 64'(value);
    else drive_var_q = 64'(value);
  endtask

  function automatic sample_t make_sample(logic [31:0] v, logic [31:0] e, logic [31:0] g,
                                          logic st);
    sample_t s;
    s.sample_value = v;
    s.sample_error = e;
    s.gap_to_next = g;
    s.series_start = st;
    return s;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.sample_value = ($urandom_range(9) == 0) ? $urandom()
                     : 32'($urandom_range(32'h60000)) - 32'h30000;
    s.sample_error = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(32'h18000);
    s.gap_to_next = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(32'h40000);
    s.series_start = ($urandom_range(7) == 0);
    return s;
  endfunction

  task automatic test_directed();
    // first word after reset without start mark behaves as a start
    send_sample(make_sample(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 1'b0));
    send_sample(make_sample(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0));
    send_sample(make_sample(32'h8000_0000, 32'h0, 32'h0000_4000, 1'b0));
    send_sample(make_sample(32'h7FFF_FFFF, 32'h0002_0000, 32'hFFFF_FFFF, 1'b0));
    send_sample(make_sample(32'h0, 32'hFFFF_FFFF, 32'h0000_8000, 1'b0));
    send_sample(make_sample(32'hFFFF_0000, 32'h0100_0000, 32'h0001_0000, 1'b0));
    send_sample(make_sample(32'h0003_0000, 32'h0, 32'h0000_1000, 1'b1));
    send_sample(make_sample(32'hFFFD_0000, 32'h0000_1000, 32'h003F_0000, 1'b0));
    send_sample(make_sample(32'h0, 32'h0, 32'h0040_0000, 1'b0));
    send_sample(make_sample(32'h1234_5678, 32'h0001_8000, 32'h0000_0001, 1'b0));
    send_sample(make_sample(32'h8000_0000, 32'h0, 32'h0, 1'b1));
    send_sample(make_sample(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0));
    send_sample(make_sample(32'h0, 32'h00FF_FFFF, 32'h0002_0000, 1'b0));
    wait_drained();
    // extreme register settings: stationary variance overflows, then vanishes
    write_reg(REG_DECAY_RATE, 32'h0000_0001);
    write_reg(REG_DRIVE_VARIANCE, 32'hFFFF_FFFF);
    send_sample(make_sample(32'h0001_0000, 32'h0, 32'h0001_0000, 1'b1));
    send_sample(make_sample(32'h0002_0000, 32'h0000_4000, 32'hFFFF_FFFF, 1'b0));
    send_sample(make_sample(32'h0002_0000, 32'h0000_4000, 32'h0001_0000, 1'b0));
    wait_drained();
    write_reg(REG_DECAY_RATE, 32'hFFFF_FFFF);
    write_reg(REG_DRIVE_VARIANCE, 32'h0);
    send_sample(make_sample(32'h0005_0000, 32'h0000_2000, 32'h0000_0001, 1'b1));
    send_sample(make_sample(32'hFFFB_0000, 32'h0000_2000, 32'h0, 1'b0));
    send_sample(make_sample(32'h0, 32'h0, 32'h0, 1'b0));
    wait_drained();
  endtask

  task automatic test_random(int n, int send_pct, int pop_pct, logic [31:0] decay,
                             logic [31:0] drive);
    write_reg(REG_DECAY_RATE, decay);
    write_reg(REG_DRIVE_VARIANCE, drive);
    send_idle_pct = send_pct;
    pop_stall_pct = pop_pct;
    for (int i = 0; i < n; i++) send_sample(random_sample());
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    sample = '0;
    cfg_we = 1'b0;
    cfg_addr = 1'b0;
    cfg_data = '0;
    errors = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    decay_rate_q = 64'h10000;
    drive_var_q = 64'h10000;
    prev_mean = 0;
    prev_var = 0;
    prev_value = 0;
    prev_error = 0;
    prev_gap = 0;
    prev_valid = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(450, 0, 0, 32'h0001_0000, 32'h0001_0000);
    test_random(450, 53, 0, 32'h0000_8000, 32'h0003_0000);
    test_random(450, 0, 53, 32'h0003_0000, 32'h0000_4000);
    test_random(450, 33, 33, $urandom_range(32'h40000, 1), $urandom_range(32'h80000));

    if (errors == 0) begin
      $display("PASS car1_kalman_filter_top");
    end else begin
      $display("FAIL car1_kalman_filter_top");
    end
    $finish;
  end

endmodule
